// File: rtl/separator_tokenizer_escape_expand_macros.svh
// Assertion macros used by the tokenizer back-end RTL.
`ifndef SEPARATOR_TOKENIZER_ESCAPE_EXPAND_MACROS_SVH
`define SEPARATOR_TOKENIZER_ESCAPE_EXPAND_MACROS_SVH

// Property checked on the rising clock edge, suspended while reset is low.
`define STE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also evaluated during reset.
`define STE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ste_pkg.sv
// Shared types, character constants and helper functions of the tokenizer.
package ste_pkg;

    // Character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_LBRACK    = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK    = 8'h5D;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
    localparam logic [7:0] CHAR_LOWER_V   = 8'h76;
    localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHAR_LOWER_B   = 8'h62;

    // Configuration register indexes
    localparam logic CFG_SEP_BYTES = 1'b0;
    localparam logic CFG_SEP_COUNT = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Step index inside one descriptor (up to seven results)
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_EXP_LAST = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EXP_DONE = 3'd6;

    // What character output a descriptor carries
    typedef enum logic [1:0] {
        CK_NONE,
        CK_PLAIN,
        CK_EXPAND
    } char_kind_t;

    // One classified input word, as handed from front to back
    typedef struct packed {
        char_kind_t  kind;
        logic [7:0]  ch;    // plain byte, or control code for an expansion
        logic        done;  // token end marker follows the characters
    } ste_desc_t;

    // Result of escape lookup
    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } esc_t;

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic esc_t escape_code(input logic [7:0] b);
        esc_t r;
        r.hit  = 1'b1;
        r.code = 8'h00;
        unique case (b)
            CHAR_LOWER_N:   r.code = 8'h0A;
            CHAR_LOWER_T:   r.code = 8'h09;
            CHAR_LOWER_V:   r.code = 8'h0B;
            CHAR_LOWER_R:   r.code = 8'h0D;
            CHAR_LOWER_F:   r.code = 8'h0C;
            CHAR_LOWER_A:   r.code = 8'h07;
            CHAR_LOWER_B:   r.code = 8'h08;
            CHAR_BACKSLASH: r.code = 8'h5C;
            CHAR_DQUOTE:    r.code = 8'h22;
            default:        r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Lower-case hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CHAR_ZERO + {4'h0, v};
        end else begin
            r = CHAR_LOWER_A + {4'h0, v} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: rtl/ste_front.sv
// Front end: separator registers, escape and token state, word classification.
module ste_front #(
    parameter int MAX_SEPARATORS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data,
    // input words
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         in_byte,
    input  logic               stream_end,
    // toward the queue
    input  ste_pkg::queue_stat_t q_stat,
    output logic               push,
    output ste_pkg::ste_desc_t push_desc
);
    import ste_pkg::*;

    localparam int SEP_CNT_W = $clog2(MAX_SEPARATORS + 1);

    logic [63:0] sep_bytes_reg;
    logic [3:0]  sep_count_reg;
    logic        esc_pending_reg, esc_pending_next;
    logic        token_open_reg, token_open_next;

    logic [SEP_CNT_W-1:0] sep_used;
    logic                 is_sep;
    esc_t                 esc;
    ste_desc_t            desc;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;

    // Clamp the separator count to the compare lanes that exist
    always_comb begin
        if (sep_count_reg > 4'(MAX_SEPARATORS)) begin
            sep_used = SEP_CNT_W'(MAX_SEPARATORS);
        end else begin
            sep_used = SEP_CNT_W'(sep_count_reg);
        end
    end

    // Parallel compare against each separator lane
    always_comb begin
        is_sep = 1'b0;
        for (int i = 0; i < MAX_SEPARATORS; i++) begin
            if ((SEP_CNT_W'(i) < sep_used) && (sep_bytes_reg[8*i +: 8] == in_byte)) begin
                is_sep = 1'b1;
            end
        end
    end

    assign esc = escape_code(in_byte);

    // Classify the word and work out the next token state
    always_comb begin
        desc.kind        = CK_NONE;
        desc.ch          = in_byte;
        desc.done        = 1'b0;
        esc_pending_next = esc_pending_reg;
        token_open_next  = token_open_reg;
        priority if (is_sep) begin
            desc.done        = token_open_reg;
            token_open_next  = 1'b0;
            esc_pending_next = 1'b0;
        end else if (esc_pending_reg) begin
            desc.kind        = esc.hit ? CK_EXPAND : CK_PLAIN;
            desc.ch          = esc.hit ? esc.code : in_byte;
            token_open_next  = 1'b1;
            esc_pending_next = 1'b0;
        end else if (in_byte == CHAR_BACKSLASH) begin
            token_open_next  = 1'b1;
            esc_pending_next = 1'b1;
        end else begin
            desc.kind        = CK_PLAIN;
            token_open_next  = 1'b1;
        end
        // stream end closes any open token
        if (stream_end) begin
            desc.done        = desc.done | token_open_next;
            token_open_next  = 1'b0;
            esc_pending_next = 1'b0;
        end
    end

    // Only words that cause results enter the queue
    assign push      = accept && ((desc.kind != CK_NONE) || desc.done);
    assign push_desc = desc;

    // Token state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pending_reg <= 1'b0;
            token_open_reg  <= 1'b0;
        end else if (accept) begin
            esc_pending_reg <= esc_pending_next;
            token_open_reg  <= token_open_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_bytes_reg <= 64'h0;
            sep_count_reg <= 4'h0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SEP_BYTES: sep_bytes_reg <= cfg_data;
                CFG_SEP_COUNT: sep_count_reg <= cfg_data[3:0];
                default:       sep_bytes_reg <= sep_bytes_reg;
            endcase
        end
    end

endmodule

// File: rtl/ste_queue.sv
// Short descriptor queue decoupling the front end from the back end.
module ste_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ste_pkg::ste_desc_t   push_desc,
    input  logic                 pop,
    output ste_pkg::ste_desc_t   head,
    output ste_pkg::queue_stat_t stat
);
    import ste_pkg::*;

    ste_desc_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: rtl/ste_back.sv
// Back end: walks each descriptor step by step into the output register.
module ste_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ste_pkg::ste_desc_t   head,
    input  ste_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           out_byte,
    output logic                 token_done,
    output logic                 run_last
);
    import ste_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              token_done_reg, token_done_next;
    logic              run_last_reg, run_last_next;

    logic              load;
    logic [STEP_W-1:0] last_step;

    assign load = !q_stat.empty && (!m_tvalid_reg || m_tready);
    assign pop  = load && (step_reg == last_step);

    // Index of the final result for the head descriptor
    always_comb begin
        unique case (head.kind)
            CK_NONE:   last_step = '0;
            CK_PLAIN:  last_step = head.done ? STEP_W'(1) : '0;
            CK_EXPAND: last_step = head.done ? STEP_EXP_DONE : STEP_EXP_LAST;
            default:   last_step = '0;
        endcase
    end

    // Result for the current step
    always_comb begin
        out_byte_next   = 8'h00;
        token_done_next = 1'b0;
        if ((head.kind == CK_EXPAND) && (step_reg <= STEP_EXP_LAST)) begin
            unique case (step_reg)
                3'd0:    out_byte_next = CHAR_LBRACK;
                3'd1:    out_byte_next = CHAR_ZERO;
                3'd2:    out_byte_next = CHAR_LOWER_X;
                3'd3:    out_byte_next = hex_char(head.ch[7:4]);
                3'd4:    out_byte_next = hex_char(head.ch[3:0]);
                default: out_byte_next = CHAR_RBRACK;
            endcase
        end else if ((head.kind == CK_PLAIN) && (step_reg == '0)) begin
            out_byte_next = head.ch;
        end else begin
            token_done_next = 1'b1;
        end
        run_last_next = (step_reg == last_step);
    end

    // Step counter and output valid
    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            step_next     = pop ? '0 : step_reg + 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg   <= out_byte_next;
            token_done_reg <= token_done_next;
            run_last_reg   <= run_last_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_byte   = out_byte_reg;
    assign token_done = token_done_reg;
    assign run_last   = run_last_reg;

`include "separator_tokenizer_escape_expand_macros.svh"

    // A partly emitted descriptor stays at the queue head
    `STE_ASSERT(a_step_has_head, aclk, aresetn, (step_reg != '0) |-> !q_stat.empty, "step without head")
    // A token end marker is always the final result of its word
    `STE_ASSERT(a_done_is_last, aclk, aresetn, (m_tvalid && token_done) |-> run_last, "done not last")
    // Results of one word follow without a bubble
    `STE_ASSERT(a_no_gap, aclk, aresetn, (m_tvalid && m_tready && !run_last) |=> m_tvalid, "gap in word")

endmodule

// File: rtl/separator_tokenizer_escape_expand.sv
// Top level of the separator tokenizer with escape expansion.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata = in_byte, s_tlast = stream_end
//  m_        out  m_tvalid / m_tready    m_tdata = out_byte, m_tuser = token_done,
//                                        m_tlast = run_last
//  cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A word is classified combinationally as it is accepted; with the queue empty
// and m_ free, its first result passes through the queue entry and the output
// register to m_. Plain bytes flow at one word per cycle while m_ is ready; an
// escape expansion gives six or seven results, one per cycle from the back-end
// step counter while m_ is ready, and the four-entry queue absorbs input while it
// runs. Words that cause no result never reach the queue. Reset is synchronous on
// aresetn and needs no clearing pass; s_tready falls only when the queue is full.
module separator_tokenizer_escape_expand #(
    parameter int MAX_SEPARATORS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] token_done
    output logic        m_tlast
);
    import ste_pkg::*;

    queue_stat_t q_stat;
    ste_desc_t   push_desc;
    ste_desc_t   head;
    logic        push;
    logic        pop;

    ste_front #(
        .MAX_SEPARATORS (MAX_SEPARATORS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_byte    (s_tdata),
        .stream_end (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_desc  (push_desc)
    );

    ste_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    ste_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_byte   (m_tdata),
        .token_done (m_tuser),
        .run_last   (m_tlast)
    );

endmodule

// File: dv/tokenizer_sb_pkg.sv
// Scoreboard class for the tokenizer: predicts result words and checks the output stream.
package tokenizer_sb_pkg;
    import ste_pkg::*;

    localparam int SEP_SLOTS = 8;

    // One result word as seen on the m_ side
    typedef struct packed {
        logic [7:0] ch;
        logic       done;
        logic       last;
    } tok_out_t;

    class tokenizer_scoreboard;
        // Shadow registers and tokenizer state
        logic [63:0] sep_bytes;
        logic [3:0]  sep_count;
        bit          escape_pending;
        bit          token_open;

        // Result words still owed by the block, oldest first
        tok_out_t token_chars_due[$];

        int errors;
        int words_noted;
        int results_checked;
        int tokens_predicted;
        int expansions;

        function new();
            sep_bytes        = '0;
            sep_count        = '0;
            escape_pending   = 1'b0;
            token_open       = 1'b0;
            errors           = 0;
            words_noted      = 0;
            results_checked  = 0;
            tokens_predicted = 0;
            expansions       = 0;
        endfunction

        function void load_register(logic idx, logic [63:0] data);
            if (idx == CFG_SEP_BYTES) begin
                sep_bytes = data;
            end else begin
                sep_count = data[3:0];
            end
        endfunction

        // Oversized counts clamp to the slot count
        function int sep_total();
            return (sep_count > SEP_SLOTS) ? SEP_SLOTS : int'(sep_count);
        endfunction

        function logic [7:0] sep_byte(int i);
            return sep_bytes[8*i +: 8];
        endfunction

        function bit is_sep(logic [7:0] b);
            for (int i = 0; i < sep_total(); i++) begin
                if (sep_bytes[8*i +: 8] == b) return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit escape_value(logic [7:0] b, output logic [7:0] code);
            bit hit;
            hit  = 1'b1;
            code = 8'h00;
            case (b)
                CHAR_LOWER_N:   code = 8'h0A;
                CHAR_LOWER_T:   code = 8'h09;
                CHAR_LOWER_V:   code = 8'h0B;
                CHAR_LOWER_R:   code = 8'h0D;
                CHAR_LOWER_F:   code = 8'h0C;
                CHAR_LOWER_A:   code = 8'h07;
                CHAR_LOWER_B:   code = 8'h08;
                CHAR_BACKSLASH: code = 8'h5C;
                CHAR_DQUOTE:    code = 8'h22;
                default:        hit  = 1'b0;
            endcase
            return hit;
        endfunction

        function logic [7:0] hex_digit(logic [3:0] v);
            if (v < 4'd10) return CHAR_ZERO + 8'(v);
            return CHAR_LOWER_A + 8'(v) - 8'd10;
        endfunction

        function void emit_char(logic [7:0] c, logic done);
            tok_out_t t;
            t.ch   = c;
            t.done = done;
            t.last = 1'b0;
            token_chars_due.push_back(t);
            if (done) tokens_predicted++;
        endfunction

        // Expected results of one accepted input word
        function void tokenize_word(logic [7:0] b, logic stream_end);
            logic [7:0] code;
            int         first;
            tok_out_t   t;
            first = token_chars_due.size();
            words_noted++;
            if (is_sep(b)) begin
                // separator wins over a pending escape
                if (token_open) emit_char(8'h00, 1'b1);
                token_open     = 1'b0;
                escape_pending = 1'b0;
            end else if (escape_pending) begin
                escape_pending = 1'b0;
                token_open     = 1'b1;
                if (escape_value(b, code)) begin
                    emit_char(CHAR_LBRACK, 1'b0);
                    emit_char(CHAR_ZERO, 1'b0);
                    emit_char(CHAR_LOWER_X, 1'b0);
                    emit_char(hex_digit(code[7:4]), 1'b0);
                    emit_char(hex_digit(code[3:0]), 1'b0);
                    emit_char(CHAR_RBRACK, 1'b0);
                    expansions++;
                end else begin
                    emit_char(b, 1'b0);
                end
            end else if (b == CHAR_BACKSLASH) begin
                escape_pending = 1'b1;
                token_open     = 1'b1;
            end else begin
                emit_char(b, 1'b0);
                token_open = 1'b1;
            end
            // stream end closes any open token after the byte itself
            if (stream_end) begin
                if (token_open) emit_char(8'h00, 1'b1);
                token_open     = 1'b0;
                escape_pending = 1'b0;
            end
            if (token_chars_due.size() > first) begin
                t      = token_chars_due.pop_back();
                t.last = 1'b1;
                token_chars_due.push_back(t);
            end
        endfunction

        function int pending();
            return token_chars_due.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 20) $display("mismatch: %s", msg);
        endtask

        task check_result(logic [7:0] ch, logic done, logic last);
            tok_out_t want;
            if (token_chars_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%02h done=%0b last=%0b",
                                          ch, done, last));
            end else begin
                want = token_chars_due.pop_front();
                results_checked++;
                if (ch !== want.ch)
                    report_mismatch($sformatf("result %0d: out_byte %02h, want %02h",
                                              results_checked, ch, want.ch));
                if (done !== want.done)
                    report_mismatch($sformatf("result %0d: token_done %0b, want %0b",
                                              results_checked, done, want.done));
                if (last !== want.last)
                    report_mismatch($sformatf("result %0d: run_last %0b, want %0b",
                                              results_checked, last, want.last));
            end
        endtask
    endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench of the separator tokenizer: stimulus, handshakes, watchdog and verdict.
module tb_top;
    import ste_pkg::*;
    import tokenizer_sb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int IDLE_PCT       = 22;

    localparam logic [7:0] ESC_LETTERS [9] = '{CHAR_LOWER_N, CHAR_LOWER_T, CHAR_LOWER_V,
                                               CHAR_LOWER_R, CHAR_LOWER_F, CHAR_LOWER_A,
                                               CHAR_LOWER_B, CHAR_BACKSLASH, CHAR_DQUOTE};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] in_byte
    logic        s_tlast   = 1'b0; // stream_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tuser;          // [0] token_done
    logic        m_tlast;          // run_last

    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    bit hold_kick = 1'b0;
    int quiet_cycles = 0;

    tokenizer_scoreboard sb = new();

    separator_tokenizer_escape_expand #(
        .MAX_SEPARATORS(SEP_SLOTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Receiver: random backpressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_kick) begin
                hold_kick = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= recv_calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL separator_tokenizer_escape_expand");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input word, with random gaps, until it is taken
    task automatic send_word(input logic [7:0] b, input logic stream_end);
        while (!send_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= stream_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.tokenize_word(b, stream_end);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.load_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_separators(input logic [63:0] bytes, input logic [3:0] count);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(CFG_SEP_BYTES, bytes);
        write_reg(CFG_SEP_COUNT, {60'h0, count});
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'h41;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(8'h21, 8'h7E));
            else b = 8'($urandom_range(0, 255));
            if (!sb.is_sep(b) && b != CHAR_BACKSLASH) break;
        end
        return b;
    endfunction

    function automatic logic [7:0] escape_follow();
        if ($urandom_range(0, 9) < 7) return ESC_LETTERS[$urandom_range(0, 8)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_separator();
        return sb.sep_byte($urandom_range(0, sb.sep_total() - 1));
    endfunction

    // Mostly well-formed tokens with random content, then a random way to end each
    task automatic send_random(input int n_words);
        int         sent;
        int         chars;
        int         reps;
        logic [7:0] b;
        sent = 0;
        while (sent < n_words) begin
            chars = $urandom_range(1, 6);
            repeat (chars) begin
                if ($urandom_range(0, 99) < 35) begin
                    send_word(CHAR_BACKSLASH, 1'b0);
                    send_word(escape_follow(), 1'b0);
                    sent += 2;
                end else begin
                    send_word(plain_byte(), 1'b0);
                    sent += 1;
                end
            end
            case ($urandom_range(0, 9))
                0: send_word(plain_byte(), 1'b1);
                // dangling escape at stream end
                1: send_word(CHAR_BACKSLASH, 1'b1);
                // noise
                2: begin
                    b = 8'($urandom_range(0, 255));
                    send_word(b, 1'($urandom_range(0, 1)));
                end
                // dangling escape ended by a separator
                3: begin
                    send_word(CHAR_BACKSLASH, 1'b0);
                    if (sb.sep_total() > 0) send_word(pick_separator(), 1'b0);
                    else send_word(plain_byte(), 1'b1);
                    sent += 1;
                end
                default: begin
                    if (sb.sep_total() == 0) begin
                        send_word(plain_byte(), 1'b1);
                    end else begin
                        reps = int'($urandom_range(1, 3));
                        repeat (reps)
                            send_word(pick_separator(), $urandom_range(0, 7) == 0);
                        sent += reps - 1;
                    end
                end
            endcase
            sent += 1;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: no separators at all
        send_random(20);
        send_word(plain_byte(), 1'b1);

        // Comma, space and 0xFF
        set_separators(64'h0000_0000_00FF_202C, 4'd3);
        send_word(8'h2C, 1'b0);            // leading separators
        send_word(8'h20, 1'b0);
        send_word(8'h00, 1'b0);            // byte zero is a plain character
        send_word(8'h61, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b0);   // \n expands
        send_word(CHAR_LOWER_N, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b0);   // \q passes q through
        send_word(8'h71, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b0);   // escaped backslash
        send_word(CHAR_BACKSLASH, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b0);   // escaped quote
        send_word(CHAR_DQUOTE, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b0);   // escaped separator ends the token
        send_word(8'h2C, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b0);   // token made of a lone backslash
        send_word(8'h20, 1'b0);
        send_word(8'hFF, 1'b0);            // separator with no token open
        send_word(8'h7F, 1'b0);
        send_word(CHAR_BACKSLASH, 1'b1);   // backslash at stream end
        send_word(8'h7A, 1'b1);            // one-char stream
        send_word(8'h2C, 1'b1);            // stream end on a separator, nothing open
        send_random(40);

        // All eight slots, including zero and backslash
        set_separators(64'h5C00_7C3B_2E09_202C, 4'd8);
        send_random(40);

        // Count above eight clamps; all-ones byte pattern
        set_separators(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_random(30);

        // Only byte zero separates
        set_separators(64'h0, 4'd1);
        send_random(30);

        // Long receiver hold-off while the sender keeps offering
        set_separators(64'h0000_0000_003B_2C20, 4'd2);
        send_calm = 1'b1;
        hold_kick = 1'b1;
        send_random(30);
        drain();

        // Stretch with no idling on either side
        recv_calm = 1'b1;
        send_random(40);
        drain();
        send_calm = 1'b0;
        recv_calm = 1'b0;

        // Separator count back to zero with stale bytes
        set_separators(64'h1234_5678_9ABC_DEF0, 4'd0);
        send_random(20);

        drain();
        repeat (20) @(posedge aclk);
        $display("covered %0d input words, %0d result words, %0d tokens, %0d escape expansions",
                 sb.words_noted, sb.results_checked, sb.tokens_predicted, sb.expansions);
        $display("separator sets: empty, three, eight slots, clamped count, zero byte, two");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS separator_tokenizer_escape_expand");
        end else begin
            $display("FAIL separator_tokenizer_escape_expand");
        end
        $finish;
    end

endmodule
